### hw/rtl/esd_pkg.sv
// Shared widths, register indexes, reset values and types of the extremum-seeking demodulator.
`default_nettype none

package esd_pkg;

  // Field widths.
  localparam int ERR_W  = 32;
  localparam int PWM_W  = 16;
  localparam int DT_W   = 16;
  localparam int DTH_W  = 16;
  localparam int ACC_W  = 48;

  // Dither pairs carried by the stream, and their single references.
  localparam int IO_PAIRS = 3;
  localparam int IO_LANES = 2 * IO_PAIRS;

  // Internal widths: cost in Q31.32, squared PWM change sum, dither times tick.
  localparam int COST_W = 63;
  localparam int SSUM_W = 33;
  localparam int MMAG_W = 31;
  localparam int TIME_W = 32;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int COEF_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_COST_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT  = 2'd2;

  localparam logic [COEF_W-1:0] COEF_ONE         = 17'd65536;
  localparam logic [COEF_W-1:0] COEF_RESET       = 17'd6554;
  localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 32'd1310720;

  // Stream payload layout.
  localparam int S_TDATA_W = 176;
  localparam int M_TDATA_W = 296;
  localparam int LP_LSB    = ERR_W;
  localparam int RP_LSB    = LP_LSB + PWM_W;
  localparam int DT_LSB    = RP_LSB + PWM_W;
  localparam int DTH_LSB   = DT_LSB + DT_W;
  localparam int FLAG_POS  = IO_LANES * ACC_W;

  // Serial multiplier operand widths.
  localparam int MUL_A_W = COST_W;
  localparam int MUL_B_W = 32;

  localparam int GAIN_COUNT_DEFAULT = 3;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

`default_nettype wire

### hw/rtl/esd_serial_mul.sv
// Bit-serial shift-and-add multiplier that retires one multiplier bit per cycle.
`default_nettype none

module esd_serial_mul
  import esd_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a_in,
  input  wire logic [B_W-1:0]     b_in,
  output mul_status_t             status,
  output logic      [A_W+B_W-1:0] product
);

  localparam int P_W = A_W + B_W;

  logic           busy;
  logic [P_W-1:0] a_sh;
  logic [P_W-1:0] acc;
  logic [B_W-1:0] b_sh;

  // The run ends as soon as no set multiplier bit is left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && b_sh == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= P_W'(a_in);
      b_sh <= b_in;
      acc  <= '0;
    end else if (busy && b_sh != '0) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign status.busy = busy;
  assign status.done = busy && (b_sh == '0);
  assign product     = acc;

endmodule

`default_nettype wire

### hw/rtl/extremum_seeking_demodulator_unit.sv
// Top level of the extremum-seeking demodulator: cost, filter and I/Q accumulation sequencer.
// Each request carries one control tick. A sample request forms the cost (squared tracking
// error plus the weighted squared PWM changes), runs it through the first-order low-pass,
// and adds the high-passed cost times each dither reference and the tick length into the
// saturating Q24.24 I/Q accumulators; a clear request (tuser set) zeroes all state. Every
// request yields exactly one result with the accumulators and the stage time-out flag. All
// products go through one shared bit-serial multiplier, and each multiply stops at the highest
// set bit of its second operand; a clear request, or a sample request that arrives after the
// stage has timed out, skips the multiplies and goes straight to the done step. A result still
// waiting in the output register holds the sequencer in its last step. A new request is taken
// only once the previous one has been worked through, while its result may still sit in the
// output register.
`default_nettype none

module extremum_seeking_demodulator_unit
  import esd_pkg::*;
#(
  parameter int GAIN_COUNT = GAIN_COUNT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // tdata from bit 0: tracking_error, left_pwm, right_pwm, tick_length, dither_sin_a,
  // dither_cos_a, dither_sin_b, dither_cos_b, dither_sin_c, dither_cos_c.
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // tuser: mode.
  input  wire logic [0:0]           s_tuser,
  // Result stream.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // tdata from bit 0: in_phase_a, quadrature_a, in_phase_b, quadrature_b, in_phase_c,
  // quadrature_c, stage_timed_out, zero fill.
  output logic [M_TDATA_W-1:0]      m_tdata,
  // Configuration writes.
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int ACC_N       = 2 * GAIN_COUNT;
  localparam int IDX_W       = $clog2(ACC_N);
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int FILT_SHIFT  = 16;
  localparam int LAM_SHIFT   = 16;
  localparam int LAM_LIMIT_W = COST_W - LAM_SHIFT;
  localparam int LAM_PROD_W  = SSUM_W + CFG_W;
  localparam int INC_SHIFT   = 38;
  localparam int INC_W       = 49;
  localparam int INC_PROD_W  = COST_W + MMAG_W;
  localparam int SUM_W       = INC_W + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DL,
    S_DR,
    S_LAM,
    S_FA,
    S_FB,
    S_HP,
    S_DT,
    S_MAG,
    S_TIME,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0]  cost_weight;
  logic [COEF_W-1:0] filter_coef;
  logic [TIME_W-1:0] time_limit;

  // Block state.
  logic [COST_W-1:0]        filt;
  logic signed [ACC_W-1:0]  acc [ACC_N];
  logic [TIME_W-1:0]        elapsed;
  logic [PWM_W-1:0]         last_lp;
  logic [PWM_W-1:0]         last_rp;

  // Latched request.
  logic [ERR_W-1:0] in_err;
  logic [PWM_W-1:0] in_lp;
  logic [PWM_W-1:0] in_rp;
  logic [DT_W-1:0]  in_dt;
  logic [DTH_W-1:0] dth [IO_LANES];

  // Working registers.
  logic [COST_W-1:0] cost;
  logic [SSUM_W-1:0] ssum;
  logic [COST_W-1:0] fa_part;
  logic [COST_W-1:0] mag;
  logic              neg_hp;
  logic [MMAG_W-1:0] mmag;
  logic              neg_inc;
  logic [IDX_W-1:0]  idx;
  logic              launched;

  // Multiplier hookup.
  logic               is_mul;
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  mul_status_t        mul_st;
  logic [MUL_P_W-1:0] mul_p;

  esd_serial_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .status  (mul_st),
    .product (mul_p)
  );

  // Operand preparation.
  logic [ERR_W-1:0]        err_abs;
  logic [PWM_W:0]          dl;
  logic [PWM_W:0]          dr;
  logic [PWM_W-1:0]        dl_abs;
  logic [PWM_W-1:0]        dr_abs;
  logic [COEF_W-1:0]       coef_eff;
  logic [COEF_W-1:0]       coef_rem;
  logic [DTH_W-1:0]        dth_sel;
  logic [DTH_W-1:0]        dth_abs;
  logic                    timed_out;

  assign err_abs  = in_err[ERR_W-1] ? (~in_err + 1'b1) : in_err;
  assign dl       = {in_lp[PWM_W-1], in_lp} - {last_lp[PWM_W-1], last_lp};
  assign dr       = {in_rp[PWM_W-1], in_rp} - {last_rp[PWM_W-1], last_rp};
  assign dl_abs   = dl[PWM_W] ? PWM_W'(-dl) : dl[PWM_W-1:0];
  assign dr_abs   = dr[PWM_W] ? PWM_W'(-dr) : dr[PWM_W-1:0];
  assign coef_eff = (filter_coef > COEF_ONE) ? COEF_ONE : filter_coef;
  assign coef_rem = COEF_ONE - coef_eff;
  assign dth_abs  = dth_sel[DTH_W-1] ? (~dth_sel + 1'b1) : dth_sel;
  assign timed_out = elapsed > time_limit;

  // Lanes beyond the stream's dither pairs see zero dither.
  always_comb begin
    dth_sel = '0;
    for (int i = 0; i < IO_LANES; i++) begin
      if (int'(idx) == i) begin
        dth_sel = dth[i];
      end
    end
  end

  always_comb begin
    unique case (state) inside
      S_ERR, S_DL, S_DR, S_LAM, S_FA, S_FB, S_DT, S_MAG: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !launched;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ERR: begin
        mul_a = MUL_A_W'(err_abs);
        mul_b = MUL_B_W'(err_abs);
      end
      S_DL: begin
        mul_a = MUL_A_W'(dl_abs);
        mul_b = MUL_B_W'(dl_abs);
      end
      S_DR: begin
        mul_a = MUL_A_W'(dr_abs);
        mul_b = MUL_B_W'(dr_abs);
      end
      S_LAM: begin
        mul_a = MUL_A_W'(ssum);
        mul_b = MUL_B_W'(cost_weight);
      end
      S_FA: begin
        mul_a = cost;
        mul_b = MUL_B_W'(coef_eff);
      end
      S_FB: begin
        mul_a = filt;
        mul_b = MUL_B_W'(coef_rem);
      end
      S_DT: begin
        mul_a = MUL_A_W'(in_dt);
        mul_b = MUL_B_W'(dth_abs);
      end
      S_MAG: begin
        mul_a = mag;
        mul_b = MUL_B_W'(mmag);
      end
      default: begin
      end
    endcase
  end

  // Weighted PWM term: a product of 2^47 or more already pins the cost at its cap.
  logic [LAM_PROD_W-1:0] lam_prod;
  logic [COST_W-1:0]     lam_term;
  logic [COST_W:0]       cost_sum;
  logic [COST_W-1:0]     cost_sat;

  assign lam_prod = mul_p[LAM_PROD_W-1:0];
  assign lam_term = (|lam_prod[LAM_PROD_W-1:LAM_LIMIT_W]) ? '1
                  : {lam_prod[LAM_LIMIT_W-1:0], {LAM_SHIFT{1'b0}}};
  assign cost_sum = {1'b0, cost} + {1'b0, lam_term};
  assign cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

  // Filter update: the sum of both scaled parts stays at or below the larger of cost and old filter.
  logic [COST_W:0] filt_sum;
  assign filt_sum = {1'b0, fa_part} + {1'b0, mul_p[FILT_SHIFT +: COST_W]};

  // Accumulator update. Any increment of 2^48 or more saturates, so a 49-bit cap is exact.
  logic [INC_W-1:0]        inc;
  logic signed [ACC_W-1:0] acc_cur;
  logic [SUM_W-1:0]        inc_ext;
  logic [SUM_W-1:0]        acc_sum;
  logic [ACC_W-1:0]        acc_sat;

  assign inc     = (|mul_p[INC_PROD_W-1:INC_SHIFT+INC_W]) ? '1 : mul_p[INC_SHIFT +: INC_W];
  assign acc_cur = acc[idx];
  assign inc_ext = neg_inc ? (~{2'b00, inc} + 1'b1) : {2'b00, inc};
  assign acc_sum = {{(SUM_W-ACC_W){acc_cur[ACC_W-1]}}, acc_cur} + inc_ext;

  always_comb begin
    if (!acc_sum[SUM_W-1] && (acc_sum[SUM_W-2:ACC_W-1] != '0)) begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (acc_sum[SUM_W-1] && (acc_sum[SUM_W-2:ACC_W-1] != '1)) begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  logic [TIME_W:0] time_sum;
  assign time_sum = {1'b0, elapsed} + (TIME_W+1)'(in_dt);

  // Result assembly; gains past GAIN_COUNT report zero.
  logic [ACC_W-1:0]     lane_out [IO_LANES];
  logic [M_TDATA_W-1:0] res_data;

  for (genvar gi = 0; gi < IO_LANES; gi++) begin : g_lane
    if (gi < ACC_N) begin : g_used
      assign lane_out[gi] = acc[gi];
    end else begin : g_unused
      assign lane_out[gi] = '0;
    end
  end

  always_comb begin
    res_data = '0;
    for (int i = 0; i < IO_LANES; i++) begin
      res_data[i*ACC_W +: ACC_W] = lane_out[i];
    end
    res_data[FLAG_POS] = timed_out;
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      launched    <= 1'b0;
      m_tvalid    <= 1'b0;
      cost_weight <= '0;
      filter_coef <= COEF_RESET;
      time_limit  <= TIME_LIMIT_RESET;
      filt        <= '0;
      elapsed     <= '0;
      last_lp     <= '0;
      last_rp     <= '0;
      for (int i = 0; i < ACC_N; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_COST_WEIGHT: cost_weight <= cfg_data;
          REG_FILTER_COEF: filter_coef <= cfg_data[COEF_W-1:0];
          REG_TIME_LIMIT:  time_limit  <= cfg_data[TIME_W-1:0];
          default: begin
          end
        endcase
      end

      // The done step reloads the output register itself.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      if (mul_start) begin
        launched <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_err <= s_tdata[ERR_W-1:0];
            in_lp  <= s_tdata[LP_LSB +: PWM_W];
            in_rp  <= s_tdata[RP_LSB +: PWM_W];
            in_dt  <= s_tdata[DT_LSB +: DT_W];
            for (int i = 0; i < IO_LANES; i++) begin
              dth[i] <= s_tdata[DTH_LSB + i*DTH_W +: DTH_W];
            end
            if (s_tuser[0]) begin
              filt    <= '0;
              elapsed <= '0;
              last_lp <= '0;
              last_rp <= '0;
              for (int i = 0; i < ACC_N; i++) begin
                acc[i] <= '0;
              end
              state <= S_DONE;
            end else if (timed_out) begin
              // A timed-out stage holds its state and only reports it.
              state <= S_DONE;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            cost     <= mul_p[COST_W-1:0];
            state    <= S_DL;
          end
        end
        S_DL: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            ssum     <= SSUM_W'(mul_p[2*PWM_W-1:0]);
            state    <= S_DR;
          end
        end
        S_DR: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            ssum     <= ssum + SSUM_W'(mul_p[2*PWM_W-1:0]);
            state    <= S_LAM;
          end
        end
        S_LAM: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            cost     <= cost_sat;
            state    <= S_FA;
          end
        end
        S_FA: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            fa_part  <= mul_p[FILT_SHIFT +: COST_W];
            state    <= S_FB;
          end
        end
        S_FB: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            filt     <= filt_sum[COST_W-1:0];
            state    <= S_HP;
          end
        end
        S_HP: begin
          neg_hp <= cost < filt;
          mag    <= (cost < filt) ? (filt - cost) : (cost - filt);
          idx    <= '0;
          state  <= S_DT;
        end
        S_DT: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            mmag     <= mul_p[MMAG_W-1:0];
            neg_inc  <= dth_sel[DTH_W-1] ^ neg_hp;
            state    <= S_MAG;
          end
        end
        S_MAG: begin
          if (mul_st.done) begin
            launched <= 1'b0;
            acc[idx] <= acc_sat;
            if ({1'b0, idx} == (IDX_W+1)'(ACC_N - 1)) begin
              state <= S_TIME;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DT;
            end
          end
        end
        S_TIME: begin
          elapsed <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
          last_lp <= in_lp;
          last_rp <= in_rp;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_data;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The shared multiplier is never restarted in the middle of a product.
  a_mul_start_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  // No multiply is left running once the sequencer is back to taking requests.
  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mul_st.busy)
    else $error("multiplier busy while idle");

  // A result only appears at the end of a request's sequence.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  // The lane counter stays within the accumulators in use.
  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DT || state == S_MAG) |-> ({1'b0, idx} < (IDX_W+1)'(ACC_N)))
    else $error("lane index out of range");

endmodule

`default_nettype wire

### tb/sv/extremum_seeking_demodulator_unit_tb.sv
// Self-checking stream testbench for the extremum-seeking demodulator with its own tick predictor.
`timescale 1ns / 1ps

module extremum_seeking_demodulator_unit_tb;
  import esd_pkg::*;

  localparam int RUN_LIMIT   = 5_000_000;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 600;

  localparam logic [63:0]         COST_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] ACC_HI   = (128'sd1 <<< (ACC_W - 1)) - 128'sd1;
  localparam logic signed [127:0] ACC_LO   = -(128'sd1 <<< (ACC_W - 1));

  // Request payload, lowest field last so the struct maps straight onto tdata.
  typedef struct packed {
    logic [IO_LANES-1:0][DTH_W-1:0] dither;
    logic [DT_W-1:0]                tick;
    logic signed [PWM_W-1:0]        right_pwm;
    logic signed [PWM_W-1:0]        left_pwm;
    logic signed [ERR_W-1:0]        tracking_error;
  } tick_fields_t;

  typedef struct packed {
    logic         mode;
    tick_fields_t f;
  } tick_req_t;

  typedef struct packed {
    logic [M_TDATA_W-FLAG_POS-2:0]  fill;
    logic                           timed_out;
    logic [IO_LANES-1:0][ACC_W-1:0] acc;
  } demod_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  extremum_seeking_demodulator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and the stage state.
  logic [31:0]             cost_weight_r;
  logic [COEF_W-1:0]       coef_r;
  logic [TIME_W-1:0]       limit_r;
  logic [63:0]             filt_cost;
  logic signed [ACC_W-1:0] accum [IO_LANES];
  logic [TIME_W-1:0]       elapsed;
  logic signed [PWM_W-1:0] prev_left;
  logic signed [PWM_W-1:0] prev_right;

  tick_req_t     pending_ticks [$];
  demod_result_t expected_accums [$];
  tick_req_t     cur_req;
  demod_result_t seen_result;
  demod_result_t want_result;
  demod_result_t fresh_result;
  logic          req_taken = 1'b0;
  logic [15:0]   gen_left = '0;
  logic [15:0]   gen_right = '0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            results_seen = 0;
  int            failures = 0;
  int            cycle_count = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  string lane_name [IO_LANES] = '{"in_phase_a", "quadrature_a", "in_phase_b",
                                  "quadrature_b", "in_phase_c", "quadrature_c"};

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic clear_demod();
    filt_cost  = '0;
    elapsed    = '0;
    prev_left  = '0;
    prev_right = '0;
    for (int k = 0; k < IO_LANES; k++) accum[k] = '0;
  endtask

  task automatic enqueue_tick(input tick_req_t t);
    pending_ticks = {pending_ticks, t};
  endtask

  task automatic advance_demod(input tick_req_t r, output demod_result_t res);
    logic signed [32:0]  err_mag;
    logic [63:0]         cost;
    logic [127:0]        wide;
    logic [127:0]        wide_old;
    logic signed [17:0]  dl;
    logic signed [17:0]  dr;
    logic [33:0]         ssum;
    logic [COEF_W-1:0]   a;
    logic signed [64:0]  hp;
    logic signed [32:0]  m;
    logic signed [127:0] prod;
    logic signed [127:0] incr;
    logic signed [127:0] nxt;
    logic [32:0]         t_sum;
    if (r.mode) begin
      clear_demod();
    end else if (!(elapsed > limit_r)) begin
      err_mag = r.f.tracking_error;
      if (err_mag < 0) err_mag = -err_mag;
      cost = err_mag[31:0] * err_mag[31:0];
      dl = r.f.left_pwm - prev_left;
      dr = r.f.right_pwm - prev_right;
      ssum = dl * dl + dr * dr;
      wide = cost_weight_r * ssum;
      wide = wide << 16;
      if (wide > COST_CAP) wide = COST_CAP;
      wide = wide + cost;
      if (wide > COST_CAP) wide = COST_CAP;
      cost = wide[63:0];

      // A coefficient above one behaves as exactly one.
      a = (coef_r > COEF_ONE) ? COEF_ONE : coef_r;
      wide = cost * a;
      wide_old = filt_cost * (COEF_ONE - a);
      filt_cost = wide[79:16] + wide_old[79:16];

      hp = $signed({1'b0, cost}) - $signed({1'b0, filt_cost});
      for (int k = 0; k < IO_LANES; k++) begin
        m = $signed(r.f.dither[k]) * $signed({1'b0, r.f.tick});
        prod = hp * m;
        // The increment truncates toward zero, so shift the magnitude.
        if (prod < 0) incr = -((-prod) >> 38);
        else incr = prod >> 38;
        nxt = accum[k] + incr;
        if (nxt > ACC_HI) nxt = ACC_HI;
        else if (nxt < ACC_LO) nxt = ACC_LO;
        accum[k] = nxt[ACC_W-1:0];
      end

      t_sum = elapsed + r.f.tick;
      elapsed = t_sum[32] ? '1 : t_sum[31:0];
      prev_left  = r.f.left_pwm;
      prev_right = r.f.right_pwm;
    end
    res = '0;
    for (int k = 0; k < IO_LANES; k++) res.acc[k] = accum[k];
    res.timed_out = (elapsed > limit_r);
  endtask

  function automatic tick_req_t make_tick(logic mode, logic [31:0] err, logic [15:0] lp,
                                          logic [15:0] rp, logic [15:0] dt, logic [95:0] dith);
    tick_req_t t;
    t.mode             = mode;
    t.f.tracking_error = err;
    t.f.left_pwm       = lp;
    t.f.right_pwm      = rp;
    t.f.tick           = dt;
    t.f.dither         = dith;
    return t;
  endfunction

  function automatic logic [15:0] rand_word16();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly slow-moving drive values and short ticks, as in a running control loop.
  function automatic tick_req_t rand_tick();
    tick_req_t t;
    int sel;
    t.mode = ($urandom_range(99) < 4);
    sel = $urandom_range(9);
    if (sel < 2) begin
      t.f.tracking_error = $urandom;
    end else if (sel == 2) begin
      case ($urandom_range(3))
        0: t.f.tracking_error = 32'h7FFF_FFFF;
        1: t.f.tracking_error = 32'h8000_0000;
        2: t.f.tracking_error = 32'h0000_0000;
        default: t.f.tracking_error = 32'hFFFF_FFFF;
      endcase
    end else begin
      t.f.tracking_error = $urandom_range(32'h3FFFF) - 32'h20000;
    end
    if ($urandom_range(9) < 7) gen_left = gen_left + 16'($urandom_range(400)) - 16'd200;
    else gen_left = rand_word16();
    if ($urandom_range(9) < 7) gen_right = gen_right + 16'($urandom_range(400)) - 16'd200;
    else gen_right = rand_word16();
    t.f.left_pwm  = gen_left;
    t.f.right_pwm = gen_right;
    sel = $urandom_range(9);
    if (sel < 6) t.f.tick = 16'($urandom_range(3000, 30));
    else if (sel < 9) t.f.tick = 16'($urandom_range(65535));
    else t.f.tick = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    for (int k = 0; k < IO_LANES; k++) begin
      if ($urandom_range(9) < 8) t.f.dither[k] = 16'($urandom);
      else t.f.dither[k] = rand_word16();
    end
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_COST_WEIGHT: cost_weight_r = value;
      REG_FILTER_COEF: coef_r = value[COEF_W-1:0];
      REG_TIME_LIMIT:  limit_r = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || s_tvalid || expected_accums.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] weight, input logic [31:0] coef,
                           input logic [31:0] limit, input int send_pct, input int recv_pct,
                           input int count);
    drain();
    write_reg(REG_COST_WEIGHT, weight);
    write_reg(REG_FILTER_COEF, coef);
    write_reg(REG_TIME_LIMIT, limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) enqueue_tick(rand_tick());
  endtask

  // Request driver: holds an offered request until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_ticks.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_req.f;
        s_tuser  <= cur_req.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with one long hold to fill the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen = results_seen + 1;
        seen_result = m_tdata;
        if (expected_accums.size() == 0) begin
          $error("result with no request pending: %h", m_tdata);
          failures = failures + 1;
        end else begin
          want_result = expected_accums.pop_front();
          for (int k = 0; k < IO_LANES; k++) begin
            if (seen_result.acc[k] !== want_result.acc[k]) begin
              $error("%s: expected %0d, got %0d", lane_name[k],
                     $signed(want_result.acc[k]), $signed(seen_result.acc[k]));
              failures = failures + 1;
            end
          end
          if (seen_result.timed_out !== want_result.timed_out) begin
            $error("stage_timed_out: expected %0d, got %0d",
                   want_result.timed_out, seen_result.timed_out);
            failures = failures + 1;
          end
          if (seen_result.fill !== want_result.fill) begin
            $error("zero fill: expected %0d, got %0d", want_result.fill, seen_result.fill);
            failures = failures + 1;
          end
        end
      end
      req_taken = s_tvalid && s_tready;
      if (req_taken) begin
        advance_demod(cur_req, fresh_result);
        expected_accums = {expected_accums, fresh_result};
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("** extremum_seeking_demodulator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    tick_req_t t;
    cost_weight_r = '0;
    coef_r        = COEF_RESET;
    limit_r       = TIME_LIMIT_RESET;
    clear_demod();
    send_idle_pct = 18;
    recv_idle_pct = 81;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values: extremes of every field, zero tick, zero dither, clear.
    enqueue_tick(make_tick(1'b1, 32'h1234_5678, 16'h0101, 16'hFEFE, 16'h4000,
                           {6{16'h2000}}));
    enqueue_tick(make_tick(1'b0, '0, '0, '0, '0, '0));
    enqueue_tick(make_tick(1'b0, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
                           {6{16'h7FFF}}));
    enqueue_tick(make_tick(1'b0, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'hFFFF,
                           {6{16'h8000}}));
    enqueue_tick(make_tick(1'b0, 32'hFFFF_FFFF, '0, '0, 16'h0001,
                           {3{16'h8000, 16'h7FFF}}));
    enqueue_tick(make_tick(1'b0, 32'h0001_0000, 16'h0010, 16'hFFF0, 16'h0000,
                           {6{16'h5555}}));
    enqueue_tick(make_tick(1'b0, 32'h0000_8000, 16'h0005, 16'hFFFB, 16'h0CCD, '0));
    enqueue_tick(make_tick(1'b1, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                           {6{16'h7FFF}}));
    drain();

    // Short stage limit: land exactly on it, pass it, then step while timed out.
    write_reg(REG_TIME_LIMIT, 32'h0002_0000);
    write_reg(REG_FILTER_COEF, 32'h0001_FFFF);
    write_reg(REG_COST_WEIGHT, 32'hFFFF_FFFF);
    enqueue_tick(make_tick(1'b1, '0, '0, '0, '0, '0));
    repeat (4) begin
      t = rand_tick();
      t.mode = 1'b0;
      t.f.tick = 16'h8000;
      enqueue_tick(t);
    end
    enqueue_tick(make_tick(1'b0, 32'h0003_0000, 16'h1000, 16'hF000, 16'h0001,
                           {6{16'h4000}}));
    enqueue_tick(make_tick(1'b0, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                           {6{16'h7FFF}}));
    enqueue_tick(make_tick(1'b1, '0, '0, '0, '0, '0));

    run_phase(32'h0000_0100, 32'd6554, 32'h0005_0000, 18, 81, 255);
    run_phase(32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF, 18, 81, 255);
    run_phase(32'h0000_0000, 32'd0, 32'h0000_0000, 81, 18, 255);
    run_phase($urandom, $urandom_range(131071), $urandom_range(32'h0020_0000), 81, 18, 255);
    run_phase($urandom_range(32'h0001_0000), 32'd65537, 32'h0003_0000, 0, 0, 255);
    run_phase(32'h0000_0001, 32'd1, 32'h000A_0000, 0, 0, 255);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (failures == 0) begin
      $display("** extremum_seeking_demodulator_unit: PASSED **");
    end else begin
      $display("** extremum_seeking_demodulator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### extremum_seeking_demodulator_unit.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_serial_mul.sv
hw/rtl/extremum_seeking_demodulator_unit.sv
tb/sv/extremum_seeking_demodulator_unit_tb.sv
